// ----- design/channel_power_meter_top_assert.svh -----
// Assertion macros used by the checker file of the channel power meter.
`ifndef CHANNEL_POWER_METER_TOP_ASSERT_SVH
`define CHANNEL_POWER_METER_TOP_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define CPM_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("channel power meter check failed");

// Check a consequent in the cycle after its antecedent.
`define CPM_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("channel power meter check failed");

`endif

// ----- design/cpm_pkg.sv -----
// Package with shared types and constants of the channel power meter.
`default_nettype none
package cpm_pkg;

	localparam int MAG_W      = 16;
	localparam int SUM_W      = 40;
	localparam int CFG_W      = 24;
	localparam int THR_W      = 16;
	localparam int FIFO_AW    = 2;
	localparam int FIFO_DEPTH = 1 << FIFO_AW;
	localparam int M_TDATA_W  = 5 * MAG_W;
	localparam int M_TUSER_W  = 2;

	localparam logic [MAG_W-1:0] MAG_MAX = {MAG_W{1'b1}};

	typedef enum logic [0:0] {
		REG_AVERAGE_COUNT   = 1'b0,
		REG_PULSE_THRESHOLD = 1'b1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_ADD,
		F_ROOT,
		F_PUSH
	} front_state_t;

	typedef enum logic [0:0] {
		B_IDLE,
		B_DIV
	} back_state_t;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic [MAG_W-1:0] average_magnitude;
		logic             average_updated;
		logic [MAG_W-1:0] pulse_average;
		logic             pulse_updated;
		logic [MAG_W-1:0] max_peak;
		logic [MAG_W-1:0] min_peak;
	} cpm_result_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_status_t;

endpackage
`default_nettype wire

// ----- design/cpm_fifo.sv -----
// Short magnitude queue between the front and back parts.
`default_nettype none
module cpm_fifo (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      push,
	input  wire logic [cpm_pkg::MAG_W-1:0] push_data,
	input  wire logic                      pop,
	output logic      [cpm_pkg::MAG_W-1:0] pop_data,
	output cpm_pkg::fifo_status_t          status
);

	logic [cpm_pkg::MAG_W-1:0]   mem_q [cpm_pkg::FIFO_DEPTH];
	logic [cpm_pkg::FIFO_AW-1:0] wr_ptr_q;
	logic [cpm_pkg::FIFO_AW-1:0] rd_ptr_q;
	logic [cpm_pkg::FIFO_AW:0]   count_q;
	logic                        do_push;
	logic                        do_pop;

	assign status.full  = (count_q == (cpm_pkg::FIFO_AW+1)'(cpm_pkg::FIFO_DEPTH));
	assign status.empty = (count_q == '0);
	assign do_push      = push && !status.full;
	assign do_pop       = pop && !status.empty;
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

// ----- design/cpm_front.sv -----
// Front part: accepts samples and forms the magnitude with a bit-serial square root.
`default_nettype none
module cpm_front #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      s_tvalid,
	output logic                           s_tready,
	input  wire logic [SAMPLE_WIDTH-1:0]   sample_i,
	input  wire logic [SAMPLE_WIDTH-1:0]   sample_q,
	output logic                           push,
	output logic      [cpm_pkg::MAG_W-1:0] push_data,
	input  wire cpm_pkg::fifo_status_t     fifo_status
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int RW  = (SW > cpm_pkg::MAG_W) ? SW : cpm_pkg::MAG_W;
	localparam int STW = $clog2(SW);

	cpm_pkg::front_state_t state_q, state_d;

	logic [SW-1:0]   abs_i_q;
	logic [SW-1:0]   abs_q_q;
	logic [2*SW-1:0] sq_i_q;
	logic [2*SW-1:0] sq_q_q;
	logic [2*SW-1:0] rad_q;
	logic [SW+1:0]   rem_q;
	logic [SW-1:0]   root_q;
	logic [STW-1:0]  step_q;

	logic [SW+3:0]   rem_sh;
	logic [SW+3:0]   trial;
	logic            ge;
	logic [RW-1:0]   root_ext;
	logic            accept;

	assign rem_sh   = {rem_q, rad_q[2*SW-1 -: 2]};
	assign trial    = {2'b00, root_q, 2'b01};
	assign ge       = (rem_sh >= trial);
	assign root_ext = RW'(root_q);
	assign push_data = (root_ext > RW'(cpm_pkg::MAG_MAX)) ? cpm_pkg::MAG_MAX
		: root_ext[cpm_pkg::MAG_W-1:0];
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpm_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		push     = 1'b0;
		unique case (state_q)
			cpm_pkg::F_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = cpm_pkg::F_MUL;
				end
			end
			cpm_pkg::F_MUL: begin
				state_d = cpm_pkg::F_ADD;
			end
			cpm_pkg::F_ADD: begin
				state_d = cpm_pkg::F_ROOT;
			end
			cpm_pkg::F_ROOT: begin
				if (step_q == '0) begin
					state_d = cpm_pkg::F_PUSH;
				end
			end
			cpm_pkg::F_PUSH: begin
				if (!fifo_status.full) begin
					push    = 1'b1;
					state_d = cpm_pkg::F_IDLE;
				end
			end
			default: begin
				state_d = cpm_pkg::F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			abs_i_q <= sample_i[SW-1] ? (~sample_i + 1'b1) : sample_i;
			abs_q_q <= sample_q[SW-1] ? (~sample_q + 1'b1) : sample_q;
		end
		if (state_q == cpm_pkg::F_MUL) begin
			sq_i_q <= abs_i_q * abs_i_q;
			sq_q_q <= abs_q_q * abs_q_q;
		end
		if (state_q == cpm_pkg::F_ADD) begin
			rad_q  <= sq_i_q + sq_q_q;
			rem_q  <= '0;
			root_q <= '0;
			step_q <= STW'(SW - 1);
		end
		if (state_q == cpm_pkg::F_ROOT) begin
			rad_q  <= rad_q << 2;
			rem_q  <= ge ? (SW+2)'(rem_sh - trial) : (SW+2)'(rem_sh);
			root_q <= {root_q[SW-2:0], ge};
			step_q <= step_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

// ----- design/cpm_div.sv -----
// Restoring divider that forms a block or pulse mean one quotient bit per cycle.
`default_nettype none
module cpm_div #(
	parameter int COUNT_WIDTH = 24
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [cpm_pkg::SUM_W-1:0] dividend,
	input  wire logic [COUNT_WIDTH-1:0]    divisor,
	output logic                           busy,
	output logic      [cpm_pkg::MAG_W-1:0] quotient
);

	localparam int CW  = COUNT_WIDTH;
	localparam int MW  = cpm_pkg::MAG_W;
	localparam int STW = $clog2(MW);

	logic           busy_q;
	logic [STW-1:0] step_q;
	logic [CW:0]    rem_q;
	logic [MW-1:0]  quo_q;
	logic [CW-1:0]  dvs_q;
	logic [CW:0]    t;
	logic           ge;

	assign t        = {rem_q[CW-1:0], quo_q[MW-1]};
	assign ge       = (t >= {1'b0, dvs_q});
	assign busy     = busy_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= STW'(MW - 1);
		end else if (busy_q) begin
			step_q <= step_q - 1'b1;
			if (step_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= (CW+1)'(dividend[cpm_pkg::SUM_W-1:MW]);
			quo_q <= dividend[MW-1:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? (t - {1'b0, dvs_q}) : t;
			quo_q <= {quo_q[MW-2:0], ge};
		end
	end

endmodule
`default_nettype wire

// ----- design/cpm_back.sv -----
// Back part: block and pulse accumulators, peak tracking and output register.
`default_nettype none
module cpm_back #(
	parameter int COUNT_WIDTH = 24
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire cpm_pkg::cfg_reg_t         cfg_index,
	input  wire logic [cpm_pkg::CFG_W-1:0] cfg_data,
	input  wire cpm_pkg::fifo_status_t     fifo_status,
	output logic                           pop,
	input  wire logic [cpm_pkg::MAG_W-1:0] pop_data,
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output cpm_pkg::cpm_result_t           out_result
);

	localparam int CW  = COUNT_WIDTH;
	localparam int SW  = cpm_pkg::SUM_W;
	localparam int MW  = cpm_pkg::MAG_W;
	localparam int TW  = (CW > cpm_pkg::CFG_W) ? CW : cpm_pkg::CFG_W;

	cpm_pkg::back_state_t state_q, state_d;

	logic [cpm_pkg::CFG_W-1:0] avg_count_q;
	logic [cpm_pkg::THR_W-1:0] pulse_thr_q;
	logic [SW-1:0]             bsum_q;
	logic [SW-1:0]             psum_q;
	logic [CW-1:0]             bcount_q;
	logic [CW-1:0]             pcount_q;
	logic [MW-1:0]             last_avg_q;
	logic [MW-1:0]             last_pavg_q;
	logic [MW-1:0]             peak_hi_q;
	logic [MW-1:0]             peak_lo_q;
	logic [MW-1:0]             mag_q;
	logic                      avg_upd_q;
	logic                      pulse_upd_q;
	logic                      out_valid_q;
	cpm_pkg::cpm_result_t      res_q;

	logic                      hit;
	logic [cpm_pkg::CFG_W-1:0] target;
	logic [SW:0]               bsum_add;
	logic [SW:0]               psum_add;
	logic [SW-1:0]             bsum_new;
	logic [SW-1:0]             psum_new;
	logic [CW-1:0]             bcount_new;
	logic [CW-1:0]             pcount_new;
	logic                      bdone;
	logic                      pdone;
	logic [MW-1:0]             peak_hi_new;
	logic [MW-1:0]             peak_lo_new;
	logic                      bdiv_start;
	logic                      pdiv_start;
	logic                      bdiv_busy;
	logic                      pdiv_busy;
	logic [MW-1:0]             bquot;
	logic [MW-1:0]             pquot;
	logic                      load_direct;
	logic                      load_div;

	assign hit        = (pop_data > pulse_thr_q);
	assign target     = (avg_count_q == '0) ? cpm_pkg::CFG_W'(1) : avg_count_q;
	assign bsum_add   = {1'b0, bsum_q} + (SW+1)'(pop_data);
	assign psum_add   = {1'b0, psum_q} + (SW+1)'(pop_data);
	assign bsum_new   = bsum_add[SW] ? {SW{1'b1}} : bsum_add[SW-1:0];
	assign psum_new   = psum_add[SW] ? {SW{1'b1}} : psum_add[SW-1:0];
	assign bcount_new = (bcount_q == {CW{1'b1}}) ? bcount_q : bcount_q + 1'b1;
	assign pcount_new = (pcount_q == {CW{1'b1}}) ? pcount_q : pcount_q + 1'b1;
	assign bdone      = (TW'(bcount_new) >= TW'(target)) || (bcount_new == {CW{1'b1}});
	assign pdone      = hit && ((TW'(pcount_new) >= TW'(target))
		|| (pcount_new == {CW{1'b1}}));
	assign peak_hi_new = (pop_data > peak_hi_q) ? pop_data : peak_hi_q;
	assign peak_lo_new = (pop_data < peak_lo_q) ? pop_data : peak_lo_q;
	assign out_valid  = out_valid_q;
	assign out_result = res_q;

	cpm_div #(.COUNT_WIDTH(CW)) u_bdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (bdiv_start),
		.dividend (bsum_new),
		.divisor  (bcount_new),
		.busy     (bdiv_busy),
		.quotient (bquot)
	);

	cpm_div #(.COUNT_WIDTH(CW)) u_pdiv (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (pdiv_start),
		.dividend (psum_new),
		.divisor  (pcount_new),
		.busy     (pdiv_busy),
		.quotient (pquot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cpm_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		pop         = 1'b0;
		bdiv_start  = 1'b0;
		pdiv_start  = 1'b0;
		load_direct = 1'b0;
		load_div    = 1'b0;
		unique case (state_q)
			cpm_pkg::B_IDLE: begin
				if (!fifo_status.empty && !out_valid_q) begin
					pop        = 1'b1;
					bdiv_start = bdone;
					pdiv_start = pdone;
					if (bdone || pdone) begin
						state_d = cpm_pkg::B_DIV;
					end else begin
						load_direct = 1'b1;
					end
				end
			end
			cpm_pkg::B_DIV: begin
				if (!bdiv_busy && !pdiv_busy) begin
					load_div = 1'b1;
					state_d  = cpm_pkg::B_IDLE;
				end
			end
			default: begin
				state_d = cpm_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_count_q <= cpm_pkg::CFG_W'(1);
			pulse_thr_q <= '0;
			bsum_q      <= '0;
			psum_q      <= '0;
			bcount_q    <= '0;
			pcount_q    <= '0;
			last_avg_q  <= '0;
			last_pavg_q <= '0;
			peak_hi_q   <= '0;
			peak_lo_q   <= cpm_pkg::MAG_MAX;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					cpm_pkg::REG_AVERAGE_COUNT:   avg_count_q <= cfg_data;
					cpm_pkg::REG_PULSE_THRESHOLD: begin
						pulse_thr_q <= cfg_data[cpm_pkg::THR_W-1:0];
					end
					default: begin
					end
				endcase
			end
			if (pop) begin
				peak_hi_q <= peak_hi_new;
				peak_lo_q <= peak_lo_new;
				bsum_q    <= bdone ? '0 : bsum_new;
				bcount_q  <= bdone ? '0 : bcount_new;
				if (hit) begin
					psum_q   <= pdone ? '0 : psum_new;
					pcount_q <= pdone ? '0 : pcount_new;
				end
			end
			if (load_div) begin
				if (avg_upd_q) begin
					last_avg_q <= bquot;
				end
				if (pulse_upd_q) begin
					last_pavg_q <= pquot;
				end
			end
			if (load_direct || load_div) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			mag_q       <= pop_data;
			avg_upd_q   <= bdone;
			pulse_upd_q <= pdone;
		end
		if (load_direct) begin
			res_q.magnitude         <= pop_data;
			res_q.average_magnitude <= last_avg_q;
			res_q.average_updated   <= 1'b0;
			res_q.pulse_average     <= last_pavg_q;
			res_q.pulse_updated     <= 1'b0;
			res_q.max_peak          <= peak_hi_new;
			res_q.min_peak          <= peak_lo_new;
		end else if (load_div) begin
			res_q.magnitude         <= mag_q;
			res_q.average_magnitude <= avg_upd_q ? bquot : last_avg_q;
			res_q.average_updated   <= avg_upd_q;
			res_q.pulse_average     <= pulse_upd_q ? pquot : last_pavg_q;
			res_q.pulse_updated     <= pulse_upd_q;
			res_q.max_peak          <= peak_hi_q;
			res_q.min_peak          <= peak_lo_q;
		end
	end

endmodule
`default_nettype wire

// ----- design/channel_power_meter_top.sv -----
// Top level of the channel power meter: magnitude, block averages and peaks.
//
// Input stream s_*: one complex sample per transfer, I in the low half of s_tdata.
// Output stream m_*: one result per sample, in order: magnitude, block mean, pulse
// mean, maximum and minimum peak in m_tdata; completion flags in m_tuser.
// Configuration: cfg_we writes cfg_data into the register picked by cfg_index
// (average_count, pulse_threshold) at the clock edge; write only while idle.
// The front takes no new sample until the magnitude of the last one is handed off;
// its square root loop retires one root bit per cycle.
// A result waits for the mean dividers when its sample closes a block or a pulse
// mean; otherwise the back part loads it straight from the queue.
// Between front and back sits a four-entry queue, so the front keeps taking
// samples while a result waits in the output register.
// Reset clears sums, counts, means and the maximum peak; the minimum peak resets
// to all ones, average_count to one and pulse_threshold to zero.
// When m_tready is low the output register holds; the queue then fills and
// s_tready drops once the front cannot hand off its next magnitude.
`default_nettype none
module channel_power_meter_top #(
	parameter int SAMPLE_WIDTH = 16,
	parameter int COUNT_WIDTH  = 24,
	localparam int S_TDATA_W   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// sample_i, sample_q
	input  wire logic [S_TDATA_W-1:0]          s_tdata,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// magnitude, average_magnitude, pulse_average, max_peak, min_peak
	output logic      [cpm_pkg::M_TDATA_W-1:0] m_tdata,
	// average_updated, pulse_updated
	output logic      [cpm_pkg::M_TUSER_W-1:0] m_tuser,
	input  wire logic                          cfg_we,
	input  wire logic                          cfg_index,
	input  wire logic [cpm_pkg::CFG_W-1:0]     cfg_data
);

	logic                       push;
	logic [cpm_pkg::MAG_W-1:0]  push_data;
	logic                       pop;
	logic [cpm_pkg::MAG_W-1:0]  pop_data;
	cpm_pkg::fifo_status_t      fifo_status;
	cpm_pkg::cpm_result_t       result;
	cpm_pkg::cfg_reg_t          cfg_sel;

	assign cfg_sel = cpm_pkg::cfg_reg_t'(cfg_index);

	cpm_front #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.sample_i    (s_tdata[SAMPLE_WIDTH-1:0]),
		.sample_q    (s_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
		.push        (push),
		.push_data   (push_data),
		.fifo_status (fifo_status)
	);

	cpm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.status    (fifo_status)
	);

	cpm_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_sel),
		.cfg_data    (cfg_data),
		.fifo_status (fifo_status),
		.pop         (pop),
		.pop_data    (pop_data),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_result  (result)
	);

	assign m_tdata = {result.min_peak, result.max_peak, result.pulse_average,
		result.average_magnitude, result.magnitude};
	assign m_tuser = {result.pulse_updated, result.average_updated};

endmodule
`default_nettype wire

// ----- design/cpm_checker.sv -----
// Port-level checker of the channel power meter and its bind.
`default_nettype none
`include "channel_power_meter_top_assert.svh"
module cpm_checker (
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          m_tvalid,
	input wire logic                          m_tready,
	input wire logic [cpm_pkg::M_TDATA_W-1:0] m_tdata,
	input wire logic [cpm_pkg::M_TUSER_W-1:0] m_tuser
);

	logic [cpm_pkg::MAG_W-1:0] mag;
	logic [cpm_pkg::MAG_W-1:0] max_pk;
	logic [cpm_pkg::MAG_W-1:0] min_pk;

	assign mag    = m_tdata[cpm_pkg::MAG_W-1:0];
	assign max_pk = m_tdata[4*cpm_pkg::MAG_W-1:3*cpm_pkg::MAG_W];
	assign min_pk = m_tdata[5*cpm_pkg::MAG_W-1:4*cpm_pkg::MAG_W];

	`CPM_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`CPM_ASSERT_SAME(a_peak_order, m_tvalid, max_pk >= min_pk)
	`CPM_ASSERT_SAME(a_mag_in_peaks, m_tvalid, (mag <= max_pk) && (mag >= min_pk))

endmodule

bind channel_power_meter_top cpm_checker u_cpm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire

// ----- test/tb_channel_power_meter_top.sv -----
// Self-checking testbench for the channel power meter: stream samples, predict and compare.
`timescale 1ns / 100ps

module tb_channel_power_meter_top;
	import cpm_pkg::*;

	localparam int CYCLE_LIMIT  = 1_000_000;
	localparam int TAIL_CYCLES  = 40;
	localparam int HOLD_CYCLES  = 600;
	localparam int PHASE_ITEMS  = 190;
	localparam int PRINT_CAP    = 40;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	class power_meter_board;
		logic [CFG_W-1:0] avg_len;
		logic [THR_W-1:0] threshold;
		logic [SUM_W-1:0] blk_sum;
		logic [CFG_W-1:0] blk_cnt;
		logic [SUM_W-1:0] pls_sum;
		logic [CFG_W-1:0] pls_cnt;
		logic [MAG_W-1:0] avg_mean;
		logic [MAG_W-1:0] pls_mean;
		logic [MAG_W-1:0] peak_hi;
		logic [MAG_W-1:0] peak_lo;
		cpm_result_t      expected_results[$];
		int               errors;
		int               seen;

		function new();
			avg_len   = 1;
			threshold = 0;
			blk_sum   = '0;
			blk_cnt   = '0;
			pls_sum   = '0;
			pls_cnt   = '0;
			avg_mean  = '0;
			pls_mean  = '0;
			peak_hi   = '0;
			peak_lo   = MAG_MAX;
			errors    = 0;
			seen      = 0;
		endfunction

		function void set_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
			if (idx == REG_AVERAGE_COUNT)
				avg_len = value;
			else
				threshold = value[THR_W-1:0];
		endfunction

		function int pending();
			return expected_results.size();
		endfunction

		function logic [MAG_W-1:0] root_floor(longint unsigned x);
			longint unsigned r;
			longint unsigned t;
			r = 0;
			for (int b = MAG_W - 1; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if (t * t <= x)
					r = t;
			end
			return r[MAG_W-1:0];
		endfunction

		function bit fold_in(inout logic [SUM_W-1:0] sum, inout logic [CFG_W-1:0] cnt,
				inout logic [MAG_W-1:0] mean, input logic [MAG_W-1:0] mag);
			logic [SUM_W:0]   wide;
			logic [CFG_W-1:0] target;
			logic [SUM_W-1:0] quot;
			wide = {1'b0, sum} + mag;
			sum = wide[SUM_W] ? {SUM_W{1'b1}} : wide[SUM_W-1:0];
			if (cnt != {CFG_W{1'b1}})
				cnt++;
			target = (avg_len == 0) ? CFG_W'(1) : avg_len;
			if (cnt >= target) begin
				quot = sum / cnt;
				mean = quot[MAG_W-1:0];
				sum  = '0;
				cnt  = '0;
				return 1'b1;
			end
			return 1'b0;
		endfunction

		function void note_sample(logic [15:0] i_raw, logic [15:0] q_raw);
			longint      si;
			longint      sq;
			cpm_result_t r;
			si = longint'($signed(i_raw));
			sq = longint'($signed(q_raw));
			r.magnitude     = root_floor(longint'(si * si + sq * sq));
			r.pulse_updated = 1'b0;
			if (r.magnitude > threshold)
				r.pulse_updated = fold_in(pls_sum, pls_cnt, pls_mean, r.magnitude);
			if (r.magnitude > peak_hi)
				peak_hi = r.magnitude;
			if (r.magnitude < peak_lo)
				peak_lo = r.magnitude;
			r.average_updated   = fold_in(blk_sum, blk_cnt, avg_mean, r.magnitude);
			r.average_magnitude = avg_mean;
			r.pulse_average     = pls_mean;
			r.max_peak          = peak_hi;
			r.min_peak          = peak_lo;
			expected_results.push_back(r);
		endfunction

		function void report(string msg);
			if (errors < PRINT_CAP)
				$display("mismatch at result %0d: %s", seen, msg);
			errors++;
		endfunction

		function void compare_field(string name, logic [MAG_W-1:0] got, logic [MAG_W-1:0] want);
			if (got !== want)
				report($sformatf("%s got %0d want %0d", name, got, want));
		endfunction

		function void check_result(logic [M_TDATA_W-1:0] data, logic [M_TUSER_W-1:0] user);
			cpm_result_t want;
			if (expected_results.size() == 0) begin
				report("result with no sample pending");
			end else begin
				want = expected_results.pop_front();
				compare_field("magnitude", data[15:0], want.magnitude);
				compare_field("average_magnitude", data[31:16], want.average_magnitude);
				compare_field("pulse_average", data[47:32], want.pulse_average);
				compare_field("max_peak", data[63:48], want.max_peak);
				compare_field("min_peak", data[79:64], want.min_peak);
				compare_field("average_updated", MAG_W'(user[0]), MAG_W'(want.average_updated));
				compare_field("pulse_updated", MAG_W'(user[1]), MAG_W'(want.pulse_updated));
			end
			seen++;
		endfunction
	endclass

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;
	logic                  cfg_we    = 1'b0;
	logic                  cfg_index = REG_AVERAGE_COUNT;
	logic [CFG_W-1:0]      cfg_data  = '0;

	power_meter_board board = new();
	int               send_pct  = 0;
	int               recv_pct  = 0;
	logic             rx_hold   = 1'b0;
	int               cycle_cnt = 0;
	event             rx_hold_go;

	channel_power_meter_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic bit coin(int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic logic [15:0] pick_component();
		logic [15:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				v = 16'($urandom);
			end
			5, 6, 7: begin
				v = 16'($urandom_range(0, 300));
				if ($urandom_range(0, 1))
					v = -v;
			end
			default: begin
				case ($urandom_range(0, 3))
					0: v = 16'h8000;
					1: v = 16'h7fff;
					2: v = 16'h0000;
					default: v = 16'hffff;
				endcase
			end
		endcase
		return v;
	endfunction

	task automatic set_idle(idle_mode_t mode);
		case (mode)
			IDLE_NONE: begin
				send_pct <= 0;
				recv_pct <= 0;
			end
			IDLE_SENDER: begin
				send_pct <= 78;
				recv_pct <= 0;
			end
			IDLE_RECEIVER: begin
				send_pct <= 0;
				recv_pct <= 78;
			end
			default: begin
				send_pct <= 6;
				recv_pct <= 6;
			end
		endcase
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.set_reg(idx, value);
		@(posedge clk);
	endtask

	task automatic send_sample(logic [15:0] i_val, logic [15:0] q_val);
		while (coin(send_pct)) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {q_val, i_val};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		board.note_sample(i_val, q_val);
	endtask

	task automatic send_random(int count);
		for (int n = 0; n < count; n++)
			send_sample(pick_component(), pick_component());
		s_tvalid <= 1'b0;
	endtask

	task automatic drain();
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	// Receiver side: check each transfer, then pick the next ready level.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser);
		m_tready <= !rx_hold && !coin(recv_pct);
	end

	initial begin
		forever begin
			@(rx_hold_go);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin
		logic [15:0] dir_i [13];
		logic [15:0] dir_q [13];
		logic [CFG_W-1:0] avg_val;
		logic [CFG_W-1:0] thr_val;
		dir_i = '{16'h0000, 16'h7fff, 16'h8000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000,
			16'h8000, 16'h7fff, 16'h0001, 16'hffff, 16'h0003, 16'hfffd};
		dir_q = '{16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000,
			16'h7fff, 16'h8000, 16'h0001, 16'h0000, 16'hfffc, 16'h0004};

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero block length acts as one; every nonzero magnitude pulses
		set_idle(IDLE_NONE);
		write_reg(REG_AVERAGE_COUNT, '0);
		write_reg(REG_PULSE_THRESHOLD, '0);
		for (int n = 0; n < 13; n++)
			send_sample(dir_i[n], dir_q[n]);
		s_tvalid <= 1'b0;
		drain();

		// lower the block length mid-block
		write_reg(REG_AVERAGE_COUNT, 24'd10);
		write_reg(REG_PULSE_THRESHOLD, 24'd100);
		for (int n = 0; n < 5; n++)
			send_sample(16'h4000 + 16'(n), 16'hc000);
		s_tvalid <= 1'b0;
		drain();
		write_reg(REG_AVERAGE_COUNT, 24'd3);
		send_sample(16'h1234, 16'h0000);
		send_sample(16'h0010, 16'hfff0);
		send_sample(16'h8000, 16'h0001);
		s_tvalid <= 1'b0;
		drain();

		for (int p = 0; p < 8; p++) begin
			case (p)
				0: begin
					avg_val = 24'd1;
					thr_val = 24'd0;
					set_idle(IDLE_NONE);
				end
				1: begin
					avg_val = 24'($urandom_range(2, 16));
					thr_val = 24'($urandom_range(0, 2000));
					set_idle(IDLE_SENDER);
				end
				2: begin
					avg_val = {CFG_W{1'b1}};
					thr_val = {CFG_W{1'b1}};
					set_idle(IDLE_RECEIVER);
				end
				3: begin
					avg_val = 24'($urandom_range(1, 64));
					thr_val = 24'($urandom_range(0, 40000));
					set_idle(IDLE_BOTH);
				end
				4: begin
					avg_val = 24'd0;
					thr_val = 24'($urandom_range(0, 65535));
					set_idle(IDLE_NONE);
				end
				5: begin
					avg_val = 24'($urandom_range(100, 300));
					thr_val = 24'($urandom);
					set_idle(IDLE_RECEIVER);
				end
				6: begin
					avg_val = 24'($urandom_range(1, 8));
					thr_val = 24'd30000;
					set_idle(IDLE_SENDER);
				end
				default: begin
					avg_val = 24'd7;
					thr_val = 24'($urandom);
					set_idle(IDLE_BOTH);
				end
			endcase
			thr_val[CFG_W-1:THR_W] = 8'($urandom);
			write_reg(REG_AVERAGE_COUNT, avg_val);
			write_reg(REG_PULSE_THRESHOLD, thr_val);
			if (p == 3)
				-> rx_hold_go;
			send_random(PHASE_ITEMS);
			drain();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/cpm_pkg.sv
design/cpm_fifo.sv
design/cpm_front.sv
design/cpm_div.sv
design/cpm_back.sv
design/channel_power_meter_top.sv
design/cpm_checker.sv
test/tb_channel_power_meter_top.sv
